>>> hdl/csub_pkg.sv
// Shared types and constants for the 4:4:4 chroma subsampler.
`timescale 1ns / 1ps
`default_nettype none
package csub_pkg;

	typedef logic [1:0]  kind_t;
	typedef logic [7:0]  smp_t;
	typedef logic [12:0] size_t;

	// result kinds
	localparam kind_t KIND_LUMA = 2'd0;
	localparam kind_t KIND_CB   = 2'd1;
	localparam kind_t KIND_CR   = 2'd2;

	// chroma modes
	localparam logic [1:0] MODE_SAMPLE_420 = 2'd0;
	localparam logic [1:0] MODE_AVG_420    = 2'd1;
	localparam logic [1:0] MODE_SAMPLE_VER = 2'd2;
	localparam logic [1:0] MODE_AVG_VER    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [1:0] MODE_RESET   = MODE_SAMPLE_420;
	localparam size_t      WIDTH_RESET  = 13'd1920;
	localparam size_t      HEIGHT_RESET = 13'd1080;
	localparam size_t      SIZE_LIMIT   = 13'd4096;

	localparam int MAX_WIDTH_DEF = 4096;

endpackage
`default_nettype wire

>>> hdl/chroma_subsample_444.sv
// Top level of the 4:4:4 to tagged luma/chroma subsampler.
// The luma result of a pixel passes the stage 1 and stage 2 registers to the result port.
// Throughput: one result per cycle unless res_stall; a pixel gives one result (luma only)
//   or three results (luma, Cb, Cr), and stage 1 waits while stage 2 is busy.
// The single result port sets the rate; line store: two reads per pixel, writes on even rows.
// Reset (arst_n low, asynchronous): counters clear, registers take their defaults, no results.
`timescale 1ns / 1ps
`default_nettype none
module chroma_subsample_444 #(
	parameter int MAX_WIDTH = csub_pkg::MAX_WIDTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// configuration writes
	input  wire                  cfg_we,
	input  wire  [1:0]           cfg_index,
	input  wire  [12:0]          cfg_data,
	// pixel channel
	input  wire                  pix_valid,
	output logic                 pix_stall,
	input  wire  [7:0]           luma,
	input  wire  [7:0]           blue_diff,
	input  wire  [7:0]           red_diff,
	// result channel
	output logic                 res_valid,
	input  wire                  res_stall,
	output logic [1:0]           kind,
	output logic [7:0]           sample,
	output logic                 last_of_pixel
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LIM_W = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
	localparam logic [14:0] MAXW_15 = 15'(MAX_WIDTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

	// configuration registers
	logic [1:0]  mode_q;
	logic [12:0] width_q;
	logic [12:0] height_q;

	// frame position
	logic [11:0] col_q;
	logic [11:0] row_q;

	// chroma of the previous pixel, Cr in the high byte
	logic [15:0] held_q;

	// chroma of the latest even row
	logic [15:0] line_mem [MAX_WIDTH];

	// stage 1: accepted pixel and its line-store reads
	logic        valid_s1;
	logic [7:0]  luma_s1;
	logic [15:0] cur_s1;
	logic [15:0] held_s1;
	logic [15:0] up_s1;
	logic [15:0] upleft_s1;
	logic        col_odd_s1;
	logic        row_odd_s1;
	logic        last_col_s1;
	logic        last_row_s1;

	// stage 2: result sequencer
	logic        valid_s2;
	logic [1:0]  kind_s2;
	logic [7:0]  luma_s2;
	logic [7:0]  cb_s2;
	logic [7:0]  cr_s2;
	logic        emit_s2;

	logic        pix_acc;
	logic        res_acc;
	logic        s2_free;
	logic        s1_adv;

	logic [12:0] w_eff;
	logic [12:0] h_eff;
	logic        last_col;
	logic        last_row;
	logic [15:0] cur;
	logic [14:0] col_w;
	logic [14:0] col_m1;
	logic [AW-1:0] addr_cur;
	logic [AW-1:0] addr_left;

	logic        emit;
	logic [7:0]  cb;
	logic [7:0]  cr;
	logic [15:0] left;
	logic [15:0] up;
	logic [15:0] upleft;
	logic [9:0]  sum4_cb;
	logic [9:0]  sum4_cr;
	logic [8:0]  sum2_cb;
	logic [8:0]  sum2_cr;

	//----------------------------------------------------------------
	// Handshake
	//----------------------------------------------------------------
	assign res_acc   = res_valid && !res_stall;
	// the sequencer frees up on the final result of its pixel
	assign s2_free   = !valid_s2 || (res_acc && last_of_pixel);
	assign s1_adv    = valid_s1 && s2_free;
	// hold the pixel channel only while stage 1 is full and cannot move on
	assign pix_stall = valid_s1 && !s2_free;
	assign pix_acc   = pix_valid && !pix_stall;

	//----------------------------------------------------------------
	// Configuration
	//----------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= csub_pkg::MODE_RESET;
			width_q  <= csub_pkg::WIDTH_RESET;
			height_q <= csub_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				csub_pkg::REG_MODE:   mode_q   <= cfg_data[1:0];
				csub_pkg::REG_WIDTH:  width_q  <= cfg_data;
				csub_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate the frame size to what the counters and line store cover
	always_comb begin
		if (width_q == 13'd0)
			w_eff = 13'd1;
		else if (width_q > 13'(LIM_W))
			w_eff = 13'(LIM_W);
		else
			w_eff = width_q;
		if (height_q == 13'd0)
			h_eff = 13'd1;
		else if (height_q > csub_pkg::SIZE_LIMIT)
			h_eff = csub_pkg::SIZE_LIMIT;
		else
			h_eff = height_q;
	end

	//----------------------------------------------------------------
	// Stage 0: position, line-store addresses
	//----------------------------------------------------------------
	assign cur      = {red_diff, blue_diff};
	// a counter at or past the end closes the row or the frame
	assign last_col = ({1'b0, col_q} + 13'd1) >= w_eff;
	assign last_row = ({1'b0, row_q} + 13'd1) >= h_eff;

	assign col_w  = 15'(col_q);
	assign col_m1 = col_w - 15'd1;
	// clamp indexes past the store to its last entry
	assign addr_cur  = (col_w  < MAXW_15) ? col_w[AW-1:0]  : LAST_ADDR;
	assign addr_left = (col_m1 < MAXW_15) ? col_m1[AW-1:0] : LAST_ADDR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

	// even rows write the line store; only odd rows use what it reads
	always_ff @(posedge clk) begin
		if (pix_acc && !row_q[0])
			line_mem[addr_cur] <= cur;
		if (pix_acc) begin
			up_s1     <= line_mem[addr_cur];
			upleft_s1 <= line_mem[addr_left];
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			luma_s1     <= luma;
			cur_s1      <= cur;
			held_s1     <= held_q;
			held_q      <= cur;
			col_odd_s1  <= col_q[0];
			row_odd_s1  <= row_q[0];
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pix_acc)
			valid_s1 <= 1'b1;
		else if (s1_adv)
			valid_s1 <= 1'b0;
	end

	//----------------------------------------------------------------
	// Stage 1: chroma window
	//----------------------------------------------------------------
	always_comb begin
		// a missing right column or lower row repeats the present one
		left   = col_odd_s1 ? held_s1 : cur_s1;
		up     = row_odd_s1 ? up_s1 : cur_s1;
		upleft = row_odd_s1 ? (col_odd_s1 ? upleft_s1 : up_s1) : left;

		sum4_cb = 10'(cur_s1[7:0]) + 10'(left[7:0]) + 10'(up[7:0]) + 10'(upleft[7:0]);
		sum4_cr = 10'(cur_s1[15:8]) + 10'(left[15:8]) + 10'(up[15:8]) + 10'(upleft[15:8]);
		sum2_cb = 9'(cur_s1[7:0]) + 9'(up[7:0]);
		sum2_cr = 9'(cur_s1[15:8]) + 9'(up[15:8]);

		case (mode_q)
			csub_pkg::MODE_SAMPLE_420: begin
				emit = !col_odd_s1 && !row_odd_s1;
				cb   = cur_s1[7:0];
				cr   = cur_s1[15:8];
			end
			csub_pkg::MODE_AVG_420: begin
				emit = (col_odd_s1 || last_col_s1) && (row_odd_s1 || last_row_s1);
				cb   = sum4_cb[9:2];
				cr   = sum4_cr[9:2];
			end
			csub_pkg::MODE_SAMPLE_VER: begin
				emit = row_odd_s1 || last_row_s1;
				cb   = cur_s1[7:0];
				cr   = cur_s1[15:8];
			end
			default: begin
				emit = row_odd_s1 || last_row_s1;
				cb   = sum2_cb[8:1];
				cr   = sum2_cr[8:1];
			end
		endcase
	end

	//----------------------------------------------------------------
	// Stage 2: deliver luma, then Cb and Cr when the window closed
	//----------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			luma_s2 <= luma_s1;
			cb_s2   <= cb;
			cr_s2   <= cr;
			emit_s2 <= emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			kind_s2  <= csub_pkg::KIND_LUMA;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
			kind_s2  <= csub_pkg::KIND_LUMA;
		end else if (res_acc) begin
			if (last_of_pixel)
				valid_s2 <= 1'b0;
			else if (kind_s2 == csub_pkg::KIND_LUMA)
				kind_s2 <= csub_pkg::KIND_CB;
			else
				kind_s2 <= csub_pkg::KIND_CR;
		end
	end

	assign res_valid = valid_s2;
	assign kind      = kind_s2;

	always_comb begin
		case (kind_s2)
			csub_pkg::KIND_LUMA: begin
				sample        = luma_s2;
				last_of_pixel = !emit_s2;
			end
			csub_pkg::KIND_CB: begin
				sample        = cb_s2;
				last_of_pixel = 1'b0;
			end
			default: begin
				sample        = cr_s2;
				last_of_pixel = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/csub_chk.sv
// Port-level checker for the chroma subsampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module csub_chk (
	input wire       clk,
	input wire       arst_n,
	input wire       pix_valid,
	input wire       pix_stall,
	input wire       res_valid,
	input wire       res_stall,
	input wire [1:0] kind,
	input wire [7:0] sample,
	input wire       last_of_pixel
);

	logic [1:0] exp_kind_q;
	logic [1:0] pend_q;
	logic       pix_acc;
	logic       res_acc;

	assign pix_acc = pix_valid && !pix_stall;
	assign res_acc = res_valid && !res_stall;

	// expected kind of the next result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_kind_q <= csub_pkg::KIND_LUMA;
		else if (res_acc) begin
			if (last_of_pixel)
				exp_kind_q <= csub_pkg::KIND_LUMA;
			else if (kind == csub_pkg::KIND_LUMA)
				exp_kind_q <= csub_pkg::KIND_CB;
			else
				exp_kind_q <= csub_pkg::KIND_CR;
		end
	end

	// pixels accepted whose final result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 2'(pix_acc) - 2'(res_acc && last_of_pixel);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) && $stable(sample)
			&& $stable(last_of_pixel))
		else $error("stalled result changed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> kind == exp_kind_q)
		else $error("result kinds out of order");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 2'd0)
		else $error("result without an accepted pixel");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3 && (pend_q != 2'd0 || !pix_stall))
		else $error("pixels in flight exceed two or idle block stalls");

endmodule

bind chroma_subsample_444 csub_chk u_csub_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.pix_valid     (pix_valid),
	.pix_stall     (pix_stall),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.kind          (kind),
	.sample        (sample),
	.last_of_pixel (last_of_pixel)
);
`default_nettype wire
